// ===== rtl/stiffness_matrix_scatter_add_unit_assert.svh =====
// Assertion macros for the stiffness matrix scatter-add unit.
// Depends on nothing; included by the checker file.
`ifndef STIFFNESS_MATRIX_SCATTER_ADD_UNIT_ASSERT_SVH
`define STIFFNESS_MATRIX_SCATTER_ADD_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in %m");

// Consequent must hold in the cycle after the antecedent.
`define SMSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed in %m");

`endif

// ===== rtl/smsa_pkg.sv =====
// Shared constants, codes and a helper function of the stiffness matrix scatter-add unit.
// No dependencies; every other file of the block but the assertion header imports it.
package smsa_pkg;

	localparam int MAX_MATRIX_SIZE       = 256;
	localparam int MAX_NODES_PER_ELEMENT = 8;
	localparam int MAX_DOFS_PER_NODE     = 3;

	localparam int IDX_W   = $clog2(MAX_MATRIX_SIZE);
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int DEPTH   = MAX_MATRIX_SIZE * MAX_MATRIX_SIZE;

	// Field widths fixed by the word format
	localparam int REQ_W   = 2;
	localparam int SLOT_W  = 3;
	localparam int NODE_W  = 8;
	localparam int LOC_W   = 5;
	localparam int VAL_W   = 32;
	localparam int RIDX_W  = 8;
	localparam int STAT_W  = 2;
	localparam int SUM_W   = 40;
	localparam int GIDX_W  = 10;
	localparam int DOFS_W  = 2;
	localparam int NODES_W = 4;
	localparam int SIZE_W  = 9;
	localparam int SIDE_W  = 6;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [REQ_W-1:0] {
		REQ_SET_NODE = 2'd0,
		REQ_ADD      = 2'd1,
		REQ_READ     = 2'd2,
		REQ_CLEAR    = 2'd3
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_SAT    = 2'd2,
		ST_BAD    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DOFS  = 2'd0,
		CFG_NODES = 2'd1,
		CFG_SIZE  = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_COL,
		S_ADD,
		S_READ,
		S_CLEAR,
		S_RESP
	} state_t;

	// Local index divided by the dofs count (1..3); by three through x*11 >> 5,
	// exact for every index below 24.
	function automatic logic [LOC_W-1:0] div_dofs(input logic [LOC_W-1:0] loc,
			input logic [DOFS_W-1:0] d);
		logic [LOC_W+4:0] prod;
		prod = (LOC_W+5)'(loc) * (LOC_W+5)'(11);
		case (d)
			2'd1: div_dofs = loc;
			2'd2: div_dofs = loc >> 1;
			2'd3: div_dofs = prod[LOC_W+4:5];
			default: div_dofs = '0;
		endcase
	endfunction

endpackage

// ===== rtl/smsa_if.sv =====
// Request and response channel interfaces of the stiffness matrix scatter-add unit.
// Depends on smsa_pkg for field widths.
interface smsa_req_if;
	import smsa_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic [SLOT_W-1:0]        slot;
	logic [NODE_W-1:0]        node_number;
	logic [LOC_W-1:0]         local_row;
	logic [LOC_W-1:0]         local_col;
	logic signed [VAL_W-1:0]  entry_value;
	logic [RIDX_W-1:0]        read_row;
	logic [RIDX_W-1:0]        read_col;

	modport source (output valid, req_type, slot, node_number, local_row, local_col,
		entry_value, read_row, read_col, input ready);
	modport sink (input valid, req_type, slot, node_number, local_row, local_col,
		entry_value, read_row, read_col, output ready);
endinterface

interface smsa_rsp_if;
	import smsa_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [SUM_W-1:0]  read_value;
	logic [GIDX_W-1:0]        global_row;
	logic [GIDX_W-1:0]        global_col;

	modport source (output valid, status, read_value, global_row, global_col, input ready);
	modport sink (input valid, status, read_value, global_row, global_col, output ready);
endinterface

// ===== rtl/stiffness_matrix_scatter_add_unit.sv =====
// Set-node decodes and replies; a read decodes, reads the RAM and replies; an add decodes,
// looks up the column, reads, adds and writes back, and replies; a clear sweeps every entry,
// one a cycle. One request is worked at a time; the matrix RAM has a single port.
// A new request is taken while a finished word waits in the output register.
// Reset (arst_n, asynchronous, active low) restores control and configuration registers and
// zeroes the node table; matrix contents are undefined until a clear request has swept them.
module stiffness_matrix_scatter_add_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	smsa_req_if.sink                        req,
	smsa_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [smsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smsa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import smsa_pkg::*;

	// Configuration
	logic [DOFS_W-1:0]  dofs_q;
	logic [NODES_W-1:0] nodes_q;
	logic [SIZE_W-1:0]  size_q;

	// Element node table
	logic [NODE_W-1:0] node_table_q [MAX_NODES_PER_ELEMENT];

	// Request word held while it is worked
	req_type_t               req_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [NODE_W-1:0]       node_q;
	logic [LOC_W-1:0]        lrow_q;
	logic [LOC_W-1:0]        lcol_q;
	logic signed [VAL_W-1:0] val_q;
	logic [RIDX_W-1:0]       rrow_q;
	logic [RIDX_W-1:0]       rcol_q;

	state_t state_q, state_d;

	logic [GIDX_W-1:0] row_q, row_d;
	logic [IDX_W-1:0]  clr_r_q, clr_r_d, clr_c_q, clr_c_d;

	// Result being built
	status_t                 res_status_q, res_status_d;
	logic signed [SUM_W-1:0] res_val_q, res_val_d;
	logic [GIDX_W-1:0]       res_row_q, res_row_d;
	logic [GIDX_W-1:0]       res_col_q, res_col_d;

	// Output register
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic signed [SUM_W-1:0] out_val_q;
	logic [GIDX_W-1:0]       out_row_q;
	logic [GIDX_W-1:0]       out_col_q;

	// Matrix RAM
	logic [SUM_W-1:0]  mem [DEPTH];
	logic [SUM_W-1:0]  mem_rdata;
	logic              mem_re, mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [SUM_W-1:0]  mem_wdata;

	logic in_ready, in_acc, out_free, out_load, nt_we;

	logic [SIZE_W-1:0]  size_use;
	logic               cfg_ok;
	logic [SIDE_W-1:0]  side;
	logic               loc_ok;
	logic [LOC_W-1:0]   lk_loc, lk_quo, lk_rem;
	logic [NODE_W-1:0]  lk_node;
	logic [GIDX_W-1:0]  lk_glob;
	logic [SUM_W:0]     sum_wide;
	logic               rd_oob, add_oob, clr_last_c, clr_last_r;

	assign size_use = (size_q > SIZE_W'(MAX_MATRIX_SIZE)) ? SIZE_W'(MAX_MATRIX_SIZE) : size_q;
	assign cfg_ok   = (dofs_q != '0) && (32'(dofs_q) <= MAX_DOFS_PER_NODE) &&
		(nodes_q != '0) && (32'(nodes_q) <= MAX_NODES_PER_ELEMENT);
	assign side     = SIDE_W'(nodes_q) * SIDE_W'(dofs_q);
	assign loc_ok   = (SIDE_W'(lrow_q) < side) && (SIDE_W'(lcol_q) < side);

	// Shared node lookup: row in decode, column in the following cycle
	assign lk_loc  = (state_q == S_COL) ? lcol_q : lrow_q;
	assign lk_quo  = div_dofs(lk_loc, dofs_q);
	assign lk_rem  = lk_loc - LOC_W'(lk_quo * LOC_W'(dofs_q));
	assign lk_node = node_table_q[lk_quo[SLOT_W-1:0]];
	assign lk_glob = GIDX_W'(lk_node) * GIDX_W'(dofs_q) + GIDX_W'(lk_rem);

	assign rd_oob  = ({1'b0, rrow_q} >= size_use) || ({1'b0, rcol_q} >= size_use);
	assign add_oob = (row_q >= GIDX_W'(size_use)) || (lk_glob >= GIDX_W'(size_use));

	assign sum_wide = {mem_rdata[SUM_W-1], mem_rdata} +
		{{(SUM_W-VAL_W+1){val_q[VAL_W-1]}}, val_q};

	assign clr_last_c = ({1'b0, clr_c_q} == size_use - 1'b1);
	assign clr_last_r = ({1'b0, clr_r_q} == size_use - 1'b1);

	assign out_free = !out_valid_q || rsp.ready;
	assign in_acc   = req.valid && in_ready;
	assign req.ready = in_ready;

	always_comb begin
		state_d      = state_q;
		row_d        = row_q;
		clr_r_d      = clr_r_q;
		clr_c_d      = clr_c_q;
		res_status_d = res_status_q;
		res_val_d    = res_val_q;
		res_row_d    = res_row_q;
		res_col_d    = res_col_q;
		mem_re       = 1'b0;
		mem_we       = 1'b0;
		mem_addr     = '0;
		mem_wdata    = '0;
		nt_we        = 1'b0;
		out_load     = 1'b0;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				res_status_d = ST_OK;
				res_val_d    = '0;
				res_row_d    = '0;
				res_col_d    = '0;
				state_d      = S_RESP;
				case (req_q)
					REQ_SET_NODE: begin
						if (32'(slot_q) < MAX_NODES_PER_ELEMENT) begin
							nt_we = 1'b1;
						end else begin
							res_status_d = ST_BAD;
						end
					end
					REQ_ADD: begin
						if (cfg_ok && loc_ok) begin
							row_d   = lk_glob;
							state_d = S_COL;
						end else begin
							res_status_d = ST_BAD;
						end
					end
					REQ_READ: begin
						if (rd_oob) begin
							res_status_d = ST_BOUNDS;
						end else begin
							mem_re   = 1'b1;
							mem_addr = {rrow_q[IDX_W-1:0], rcol_q[IDX_W-1:0]};
							state_d  = S_READ;
						end
					end
					REQ_CLEAR: begin
						clr_r_d = '0;
						clr_c_d = '0;
						if (size_use != '0) begin
							state_d = S_CLEAR;
						end
					end
					default: begin
						res_status_d = ST_BAD;
					end
				endcase
			end
			S_COL: begin
				res_row_d = row_q;
				res_col_d = lk_glob;
				if (add_oob) begin
					res_status_d = ST_BOUNDS;
					state_d      = S_RESP;
				end else begin
					mem_re   = 1'b1;
					mem_addr = {row_q[IDX_W-1:0], lk_glob[IDX_W-1:0]};
					state_d  = S_ADD;
				end
			end
			S_ADD: begin
				// Entry stored at the address still held from the read
				mem_we   = 1'b1;
				mem_addr = {res_row_q[IDX_W-1:0], res_col_q[IDX_W-1:0]};
				if (!sum_wide[SUM_W] && sum_wide[SUM_W-1]) begin
					mem_wdata    = SUM_MAX;
					res_status_d = ST_SAT;
				end else if (sum_wide[SUM_W] && !sum_wide[SUM_W-1]) begin
					mem_wdata    = SUM_MIN;
					res_status_d = ST_SAT;
				end else begin
					mem_wdata = sum_wide[SUM_W-1:0];
				end
				state_d = S_RESP;
			end
			S_READ: begin
				res_val_d = mem_rdata;
				state_d   = S_RESP;
			end
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = {clr_r_q, clr_c_q};
				if (clr_last_c) begin
					clr_c_d = '0;
					clr_r_d = clr_r_q + 1'b1;
					if (clr_last_r) begin
						state_d = S_RESP;
					end
				end else begin
					clr_c_d = clr_c_q + 1'b1;
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					in_ready = 1'b1;
					state_d  = req.valid ? S_DECODE : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			dofs_q      <= DOFS_W'(2);
			nodes_q     <= NODES_W'(4);
			size_q      <= SIZE_W'(256);
			for (int i = 0; i < MAX_NODES_PER_ELEMENT; i++) begin
				node_table_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (nt_we) begin
				node_table_q[slot_q] <= node_q;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DOFS:  dofs_q  <= cfg_data[DOFS_W-1:0];
					CFG_NODES: nodes_q <= cfg_data[NODES_W-1:0];
					CFG_SIZE:  size_q  <= cfg_data[SIZE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= req_type_t'(req.req_type);
			slot_q <= req.slot;
			node_q <= req.node_number;
			lrow_q <= req.local_row;
			lcol_q <= req.local_col;
			val_q  <= req.entry_value;
			rrow_q <= req.read_row;
			rcol_q <= req.read_col;
		end
		row_q        <= row_d;
		clr_r_q      <= clr_r_d;
		clr_c_q      <= clr_c_d;
		res_status_q <= res_status_d;
		res_val_q    <= res_val_d;
		res_row_q    <= res_row_d;
		res_col_q    <= res_col_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_val_q    <= res_val_q;
			out_row_q    <= res_row_q;
			out_col_q    <= res_col_q;
		end
	end

	// Matrix RAM, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata <= mem[mem_addr];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_val_q;
	assign rsp.global_row = out_row_q;
	assign rsp.global_col = out_col_q;

endmodule

// ===== rtl/smsa_checker.sv =====
// Port-level checks of the stiffness matrix scatter-add unit, bound to the top level.
// Depends on smsa_pkg and stiffness_matrix_scatter_add_unit_assert.svh.
`include "stiffness_matrix_scatter_add_unit_assert.svh"

module smsa_port_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [smsa_pkg::STAT_W-1:0] out_status,
	input logic [smsa_pkg::SUM_W-1:0]  out_read_value
);
	import smsa_pkg::*;

	logic       in_acc, out_acc;
	logic [1:0] pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Count words taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`SMSA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_status) && $stable(out_read_value))
	`SMSA_ASSERT_NOW(a_no_spurious_out, clk, arst_n, out_acc, pend_q != 2'd0)
	`SMSA_ASSERT_NOW(a_pending_bound, clk, arst_n, in_acc, (pend_q != 2'd2) || out_acc)
	`SMSA_ASSERT_NOW(a_value_zero_on_fail, clk, arst_n,
		out_valid && (out_status != ST_OK), out_read_value == '0)

endmodule

bind stiffness_matrix_scatter_add_unit smsa_port_checker u_smsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.out_status     (rsp.status),
	.out_read_value (rsp.read_value)
);

// ===== sim/smsa_checker.sv =====
// Scoreboard for the stiffness matrix scatter-add unit: snoops register writes and request
// words, predicts each reply word and compares replies in order, field by field.
// Depends on smsa_pkg and the channel interfaces of smsa_if.sv.
module smsa_checker
	import smsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	smsa_req_if                   req,
	smsa_rsp_if                   rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending,
	output int                    replies_checked,
	output int                    saturations
);

	typedef struct packed {
		status_t                 status;
		logic signed [SUM_W-1:0] value;
		logic [GIDX_W-1:0]       grow;
		logic [GIDX_W-1:0]       gcol;
	} reply_t;

	logic signed [SUM_W-1:0] sums [DEPTH];
	logic [NODE_W-1:0]       node_slots [MAX_NODES_PER_ELEMENT];
	logic [DOFS_W-1:0]       dofs;
	logic [NODES_W-1:0]      nodes;
	logic [SIZE_W-1:0]       size_reg;
	reply_t                  due_replies [$];
	reply_t                  want;
	reply_t                  got;

	// Work out the reply to one request and update the matrix and node slots.
	function automatic reply_t apply_request(input req_type_t kind,
			input logic [SLOT_W-1:0] slot, input logic [NODE_W-1:0] node,
			input logic [LOC_W-1:0] lrow, input logic [LOC_W-1:0] lcol,
			input logic signed [VAL_W-1:0] value,
			input logic [RIDX_W-1:0] rrow, input logic [RIDX_W-1:0] rcol);
		reply_t r;
		int     span;
		int     d;
		int     n;
		int     lr;
		int     lc;
		int     row;
		int     col;
		longint total;
		r.status = ST_OK;
		r.value  = '0;
		r.grow   = '0;
		r.gcol   = '0;
		span = (int'(size_reg) > MAX_MATRIX_SIZE) ? MAX_MATRIX_SIZE : int'(size_reg);
		d  = int'(dofs);
		n  = int'(nodes);
		lr = int'(lrow);
		lc = int'(lcol);
		case (kind)
			REQ_SET_NODE: begin
				node_slots[slot] = node;
			end
			REQ_ADD: begin
				if (d == 0 || d > MAX_DOFS_PER_NODE || n == 0 || n > MAX_NODES_PER_ELEMENT ||
						lr >= n * d || lc >= n * d) begin
					r.status = ST_BAD;
				end else begin
					row = int'(node_slots[lr / d]) * d + lr % d;
					col = int'(node_slots[lc / d]) * d + lc % d;
					r.grow = GIDX_W'(row);
					r.gcol = GIDX_W'(col);
					if (row >= span || col >= span) begin
						r.status = ST_BOUNDS;
					end else begin
						total = longint'(sums[row * MAX_MATRIX_SIZE + col]) + longint'(value);
						if (total > longint'(SUM_MAX)) begin
							total = longint'(SUM_MAX);
							r.status = ST_SAT;
						end else if (total < longint'(SUM_MIN)) begin
							total = longint'(SUM_MIN);
							r.status = ST_SAT;
						end
						sums[row * MAX_MATRIX_SIZE + col] = SUM_W'(total);
					end
				end
			end
			REQ_READ: begin
				row = int'(rrow);
				col = int'(rcol);
				if (row >= span || col >= span) r.status = ST_BOUNDS;
				else r.value = sums[row * MAX_MATRIX_SIZE + col];
			end
			default: begin
				for (int i = 0; i < span; i++)
					for (int j = 0; j < span; j++)
						sums[i * MAX_MATRIX_SIZE + j] = '0;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (sums[i]) sums[i] = '0;
			foreach (node_slots[i]) node_slots[i] = '0;
			dofs            = DOFS_W'(2);
			nodes           = NODES_W'(4);
			size_reg        = SIZE_W'(MAX_MATRIX_SIZE);
			due_replies.delete();
			errors          = 0;
			pending         = 0;
			replies_checked = 0;
			saturations     = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DOFS:  dofs = cfg_data[DOFS_W-1:0];
					CFG_NODES: nodes = cfg_data[NODES_W-1:0];
					CFG_SIZE:  size_reg = cfg_data[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				due_replies.push_back(apply_request(req_type_t'(req.req_type), req.slot,
					req.node_number, req.local_row, req.local_col, req.entry_value,
					req.read_row, req.read_col));
			if (rsp.valid && rsp.ready) begin
				got.status = status_t'(rsp.status);
				got.value  = rsp.read_value;
				got.grow   = rsp.global_row;
				got.gcol   = rsp.global_col;
				if (due_replies.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("smsa_checker: reply word with none due: status %0d value %0d",
							got.status, got.value, " row %0d col %0d", got.grow, got.gcol);
				end else begin
					want = due_replies.pop_front();
					replies_checked++;
					if (want.status == ST_SAT) saturations++;
					if (got.status !== want.status || got.value !== want.value ||
							got.grow !== want.grow || got.gcol !== want.gcol) begin
						errors++;
						if (errors <= 10)
							$display("smsa_checker: reply %0d expected status %0d value %0d",
								replies_checked, want.status, want.value,
								" row %0d col %0d, got status %0d value %0d row %0d col %0d",
								want.grow, want.gcol, got.status, got.value, got.grow, got.gcol);
					end
				end
			end
			pending = due_replies.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Top of the stiffness matrix scatter-add unit testbench: clock, reset, request stimulus,
// reply back-pressure and register writes; smsa_checker does the prediction and compare.
// Depends on smsa_pkg, smsa_if.sv, the unit itself and sim/smsa_checker.sv.
module tb_top;
	import smsa_pkg::*;

	// Slowest run: one full clear, a few hundred small clears and ~1400 words with stalls;
	// the cycle limit leaves a wide margin over it.
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int LONG_HOLD   = 400;
	localparam int HAMMER_ADDS = 275;

	typedef struct {
		req_type_t          kind;
		logic [SLOT_W-1:0]  slot;
		logic [NODE_W-1:0]  node;
		logic [LOC_W-1:0]   lrow;
		logic [LOC_W-1:0]   lcol;
		logic [VAL_W-1:0]   value;
		logic [RIDX_W-1:0]  rrow;
		logic [RIDX_W-1:0]  rcol;
	} request_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int          fail_count;
	int          words_due;
	int          replies_checked;
	int          sat_count;
	int unsigned words_sent;
	int          cycle_count;
	int          settings_used;
	int          cur_dofs;
	int          cur_nodes;
	int          cur_size;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          long_hold_due;
	bit          long_hold_done;

	smsa_req_if req_ch ();
	smsa_rsp_if rsp_ch ();

	stiffness_matrix_scatter_add_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	smsa_checker matrix_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.errors          (fail_count),
		.pending         (words_due),
		.replies_checked (replies_checked),
		.saturations     (sat_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top: errors");
		$finish;
	end

	// Reply side: random stalls, plus one long hold-off so the unit backs up.
	initial begin
		rsp_ch.ready = 1'b0;
		long_hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_due && !long_hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic request_t blank_word();
		request_t w;
		w.kind  = req_type_t'($urandom_range(3));
		w.slot  = SLOT_W'($urandom);
		w.node  = NODE_W'($urandom);
		w.lrow  = LOC_W'($urandom);
		w.lcol  = LOC_W'($urandom);
		w.value = $urandom;
		w.rrow  = RIDX_W'($urandom);
		w.rcol  = RIDX_W'($urandom);
		return w;
	endfunction

	function automatic logic [VAL_W-1:0] random_value();
		if ($urandom_range(1) == 1) return $urandom;
		return VAL_W'(int'($urandom_range(1048576)) - 524288);
	endfunction

	function automatic int span_in_use();
		return (cur_size > MAX_MATRIX_SIZE) ? MAX_MATRIX_SIZE : cur_size;
	endfunction

	// Offer one request word and hold it until the unit takes it.
	task automatic offer_word(input request_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= w.kind;
		req_ch.slot        <= w.slot;
		req_ch.node_number <= w.node;
		req_ch.local_row   <= w.lrow;
		req_ch.local_col   <= w.lcol;
		req_ch.entry_value <= w.value;
		req_ch.read_row    <= w.rrow;
		req_ch.read_col    <= w.rcol;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_set(input int slot, input int node);
		request_t w;
		w = blank_word();
		w.kind = REQ_SET_NODE;
		w.slot = SLOT_W'(slot);
		w.node = NODE_W'(node);
		offer_word(w);
	endtask

	task automatic send_add(input int lr, input int lc, input logic [VAL_W-1:0] value);
		request_t w;
		w = blank_word();
		w.kind  = REQ_ADD;
		w.lrow  = LOC_W'(lr);
		w.lcol  = LOC_W'(lc);
		w.value = value;
		offer_word(w);
	endtask

	task automatic send_read(input int row, input int col);
		request_t w;
		w = blank_word();
		w.kind = REQ_READ;
		w.rrow = RIDX_W'(row);
		w.rcol = RIDX_W'(col);
		offer_word(w);
	endtask

	task automatic send_clear();
		request_t w;
		w = blank_word();
		w.kind = REQ_CLEAR;
		offer_word(w);
	endtask

	// Drop valid and wait until every reply word has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (words_due != 0);
	endtask

	task automatic write_settings(input int d, input int n, input int s);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DOFS;
		cfg_data  <= CFG_DATA_W'(d);
		@(negedge clk);
		cfg_index <= CFG_NODES;
		cfg_data  <= CFG_DATA_W'(n);
		@(negedge clk);
		cfg_index <= CFG_SIZE;
		cfg_data  <= CFG_DATA_W'(s);
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_dofs  = d;
		cur_nodes = n;
		cur_size  = s;
		settings_used++;
	endtask

	task automatic random_settings();
		write_settings($urandom_range(1, 3), $urandom_range(1, 8),
			($urandom_range(3) == 0) ? $urandom_range(49, 256) : $urandom_range(1, 48));
	endtask

	function automatic int pick_local(input int side);
		if ($urandom_range(9) == 0) return $urandom_range(31);
		return $urandom_range(side - 1);
	endfunction

	// One element: fill its node slots, scatter some entries, read a few random entries.
	task automatic assemble_element();
		int span;
		int top_node;
		int side;
		span     = span_in_use();
		top_node = (span - 1) / cur_dofs;
		side     = cur_nodes * cur_dofs;
		for (int s = 0; s < cur_nodes; s++)
			send_set(s, ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(top_node));
		repeat ($urandom_range(3, 12))
			send_add(pick_local(side), pick_local(side), random_value());
		repeat ($urandom_range(3))
			send_read($urandom_range(span - 1), $urandom_range(span - 1));
	endtask

	// Pound one entry until its sum clamps; the setting in use keeps clears cheap.
	task automatic hammer_entry(input bit negative);
		send_clear();
		send_set(0, 0);
		repeat (HAMMER_ADDS)
			send_add(0, 0, negative ? (32'h8000_0000 | VAL_W'($urandom_range(24'hFF_FFFF)))
				: (32'h7F00_0000 | VAL_W'($urandom_range(24'hFF_FFFF))));
		send_read(0, 0);
	endtask

	task automatic run_segment(input int quota);
		int unsigned goal;
		int          roll;
		int          span;
		request_t    w;
		goal = words_sent + quota;
		span = span_in_use();
		while (words_sent < goal) begin
			roll = $urandom_range(99);
			if (roll < 60) begin
				assemble_element();
			end else if (roll < 75) begin
				send_read($urandom_range(span - 1), $urandom_range(span - 1));
			end else if (roll < 80 && span <= 64) begin
				send_clear();
			end else begin
				// noise: any word, but keep clears of a large square out
				w = blank_word();
				if (w.kind == REQ_CLEAR && span > 64) w.kind = REQ_READ;
				offer_word(w);
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_DOFS;
		cfg_data           = '0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_SET_NODE;
		req_ch.slot        = '0;
		req_ch.node_number = '0;
		req_ch.local_row   = '0;
		req_ch.local_col   = '0;
		req_ch.entry_value = '0;
		req_ch.read_row    = '0;
		req_ch.read_col    = '0;
		long_hold_due      = 1'b0;
		words_sent         = 0;
		settings_used      = 1;
		cur_dofs           = 2;
		cur_nodes          = 4;
		cur_size           = MAX_MATRIX_SIZE;
		send_idle_pct      = 26;
		recv_idle_pct      = 46;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// matrix is undefined until swept: clear the whole of it first
		send_clear();
		send_set(7, 255);
		send_set(0, 0);
		send_set(1, 127);
		send_set(3, 100);
		send_add(0, 0, 32'h7FFF_FFFF);
		send_add(1, 1, 32'h8000_0000);
		send_add(15, 14, random_value());
		send_add(31, 0, random_value());
		send_add(0, 31, random_value());
		send_add(6, 7, 32'h0001_0000);
		send_add(2, 3, 32'hFFFF_FFFF);
		send_read(0, 0);
		send_read(1, 1);
		send_read(255, 255);
		send_read(200, 201);
		write_settings(3, 8, 511);
		send_add(23, 23, random_value());
		send_read(255, 254);
		write_settings(1, 1, 1);
		send_add(0, 0, random_value());
		send_add(1, 0, random_value());
		send_read(0, 1);
		send_read(0, 0);
		write_settings(0, 15, 0);
		send_add(0, 0, random_value());
		send_read(0, 0);
		send_clear();
		write_settings(2, 9, 8);
		send_add(0, 0, random_value());
		write_settings(3, 0, 300);
		send_add(0, 0, random_value());

		write_settings(3, 8, 256);
		run_segment(100);
		write_settings(2, 3, 20);
		hammer_entry(1'b0);
		run_segment(100);
		random_settings();
		run_segment(100);

		send_idle_pct = 46;
		recv_idle_pct = 26;
		write_settings(1, 1, 1);
		run_segment(100);
		write_settings(3, 8, 511);
		run_segment(100);
		write_settings(1, 8, 8);
		hammer_entry(1'b1);
		run_segment(100);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_settings();
		long_hold_due = 1'b1;
		run_segment(100);
		write_settings(3, 8, 64);
		run_segment(100);

		drain();
		repeat (10) @(negedge clk);
		$display("tb_top: %0d request words sent, %0d replies checked over %0d register settings",
			words_sent, replies_checked, settings_used);
		$display("tb_top: %0d saturated sums seen; reply side held off %0d cycles once",
			sat_count, LONG_HOLD);
		if (fail_count == 0 && words_due == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
